/* sv/sckt_pkg.sv */
// ----------------------------------------------------------------------------
// sckt_pkg
// Shared types, codes and helpers for the sorted cell key table.
// ----------------------------------------------------------------------------
package sckt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [1:0]  kind;
    logic [15:0] arg_ref;
    logic [7:0]  arg_count;
    logic [5:0]  index;
  } req_t;

  typedef struct packed {
    logic [7:0]  col;
    logic [7:0]  row;
    logic [1:0]  kind;
    logic [15:0] arg_ref;
    logic [7:0]  arg_count;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [5:0]  start_index;
    logic [6:0]  match_count;
    logic [7:0]  entry_col;
    logic [7:0]  entry_row;
    logic [1:0]  entry_kind;
    logic [15:0] entry_arg_ref;
    logic [7:0]  entry_arg_count;
    logic [6:0]  entry_total;
  } rsp_t;

  typedef enum logic [1:0] {
    CMP_LT,
    CMP_EQ,
    CMP_GT
  } cmp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SCMP,
    ST_SHRD,
    ST_SHWR,
    ST_PUT,
    ST_DNRD,
    ST_DNCMP,
    ST_UPRD,
    ST_UPCMP,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  // row is the primary field, col the secondary
  function automatic cmp_t key_cmp(logic [7:0] row, logic [7:0] col, entry_t e);
    logic [15:0] a;
    logic [15:0] b;
    a = {row, col};
    b = {e.row, e.col};
    if (a < b) begin
      return CMP_LT;
    end else if (a > b) begin
      return CMP_GT;
    end
    return CMP_EQ;
  endfunction

endpackage

/* sv/sckt_mem.sv */
// ----------------------------------------------------------------------------
// sckt_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sckt_mem #(
  parameter int TABLE_DEPTH = sckt_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  sckt_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output sckt_pkg::entry_t rdata
);

  sckt_pkg::entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/sckt_ctrl.sv */
// ----------------------------------------------------------------------------
// sckt_ctrl
// Sequencer: binary search, upward shift on insert, run scan on lookup,
// indexed read. Every access goes through the single store port pair.
// ----------------------------------------------------------------------------
module sckt_ctrl #(
  parameter int TABLE_DEPTH = sckt_pkg::TABLE_DEPTH_DEF,
  localparam int AW   = $clog2(TABLE_DEPTH),
  localparam int CW   = $clog2(TABLE_DEPTH + 1),
  localparam int CMPW = (CW > 6) ? CW : 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  sckt_pkg::req_t   req,
  output logic             res_valid,
  input  logic             res_ready,
  output sckt_pkg::rsp_t   res,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output sckt_pkg::entry_t mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  sckt_pkg::entry_t mem_rdata
);

  sckt_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;

  logic [1:0]       op, op_next;
  sckt_pkg::entry_t new_entry, new_entry_next;
  logic [CW-1:0]    lo, lo_next;
  logic [CW-1:0]    hi, hi_next;
  logic [CW-1:0]    pos, pos_next;
  logic [CW-1:0]    ptr, ptr_next;
  logic [CW-1:0]    first, first_next;
  logic [CW-1:0]    run_len, run_len_next;

  logic [1:0]       res_status, res_status_next;
  logic             res_found, res_found_next;
  logic [5:0]       res_start, res_start_next;
  logic [6:0]       res_mcount, res_mcount_next;
  sckt_pkg::entry_t res_entry, res_entry_next;

  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid;
  logic [CW-1:0]    ptr_dec;
  logic [CW-1:0]    first_dec;
  logic [CW:0]      up_addr;
  sckt_pkg::cmp_t   cmp;

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[CW:1];
  assign ptr_dec   = ptr - CW'(1);
  assign first_dec = first - CW'(1);
  assign up_addr   = {1'b0, first} + {1'b0, run_len};
  assign cmp       = sckt_pkg::key_cmp(new_entry.row, new_entry.col, mem_rdata);

  assign res.status          = res_status;
  assign res.found           = res_found;
  assign res.start_index     = res_start;
  assign res.match_count     = res_mcount;
  assign res.entry_col       = res_entry.col;
  assign res.entry_row       = res_entry.row;
  assign res.entry_kind      = res_entry.kind;
  assign res.entry_arg_ref   = res_entry.arg_ref;
  assign res.entry_arg_count = res_entry.arg_count;
  assign res.entry_total     = 7'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sckt_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    new_entry  <= new_entry_next;
    lo         <= lo_next;
    hi         <= hi_next;
    pos        <= pos_next;
    ptr        <= ptr_next;
    first      <= first_next;
    run_len    <= run_len_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_start  <= res_start_next;
    res_mcount <= res_mcount_next;
    res_entry  <= res_entry_next;
  end

  // Reads and writes sit in separate states, so the store never sees a
  // read and a write of the same entry in one cycle.
  always_comb begin
    state_next      = state;
    count_next      = count;
    op_next         = op;
    new_entry_next  = new_entry;
    lo_next         = lo;
    hi_next         = hi;
    pos_next        = pos;
    ptr_next        = ptr;
    first_next      = first;
    run_len_next    = run_len;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_start_next  = res_start;
    res_mcount_next = res_mcount;
    res_entry_next  = res_entry;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = new_entry;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    res_valid       = 1'b0;
    req_stall       = (state != sckt_pkg::ST_IDLE);

    unique case (state)
      sckt_pkg::ST_IDLE: begin
        if (req_valid) begin
          op_next                  = req.operation;
          new_entry_next.col       = req.col;
          new_entry_next.row       = req.row;
          new_entry_next.kind      = req.kind;
          new_entry_next.arg_ref   = req.arg_ref;
          new_entry_next.arg_count = req.arg_count;
          res_status_next          = sckt_pkg::STAT_OK;
          res_found_next           = 1'b0;
          res_start_next           = '0;
          res_mcount_next          = '0;
          res_entry_next           = '0;
          lo_next                  = '0;
          hi_next                  = count;
          unique case (req.operation)
            sckt_pkg::OP_INSERT: begin
              if (count == CW'(TABLE_DEPTH)) begin
                res_status_next = sckt_pkg::STAT_FULL;
                state_next      = sckt_pkg::ST_DONE;
              end else begin
                state_next = sckt_pkg::ST_SRCH;
              end
            end
            sckt_pkg::OP_LOOKUP: begin
              state_next = sckt_pkg::ST_SRCH;
            end
            sckt_pkg::OP_READ: begin
              if (CMPW'(req.index) >= CMPW'(count)) begin
                res_status_next = sckt_pkg::STAT_BAD_INDEX;
                state_next      = sckt_pkg::ST_DONE;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(req.index);
                state_next = sckt_pkg::ST_RDWAIT;
              end
            end
            default: begin
              state_next = sckt_pkg::ST_DONE;
            end
          endcase
        end
      end

      sckt_pkg::ST_SRCH: begin
        if (lo < hi) begin
          mem_re     = 1'b1;
          mem_raddr  = mid[AW-1:0];
          pos_next   = mid;
          state_next = sckt_pkg::ST_SCMP;
        end else begin
          // miss: lo is the insert slot
          pos_next       = lo;
          res_start_next = 6'(lo);
          if (op == sckt_pkg::OP_INSERT) begin
            ptr_next   = count;
            state_next = sckt_pkg::ST_SHRD;
          end else begin
            state_next = sckt_pkg::ST_DONE;
          end
        end
      end

      sckt_pkg::ST_SCMP: begin
        case (cmp)
          sckt_pkg::CMP_LT: begin
            hi_next    = pos;
            state_next = sckt_pkg::ST_SRCH;
          end
          sckt_pkg::CMP_GT: begin
            lo_next    = pos + CW'(1);
            state_next = sckt_pkg::ST_SRCH;
          end
          default: begin
            res_start_next = 6'(pos);
            if (op == sckt_pkg::OP_INSERT) begin
              ptr_next   = count;
              state_next = sckt_pkg::ST_SHRD;
            end else begin
              res_found_next = 1'b1;
              first_next     = pos;
              run_len_next   = CW'(1);
              state_next     = sckt_pkg::ST_DNRD;
            end
          end
        endcase
      end

      // shift entries [pos, count) up by one, top first
      sckt_pkg::ST_SHRD: begin
        if (ptr > pos) begin
          mem_re     = 1'b1;
          mem_raddr  = ptr_dec[AW-1:0];
          state_next = sckt_pkg::ST_SHWR;
        end else begin
          state_next = sckt_pkg::ST_PUT;
        end
      end

      sckt_pkg::ST_SHWR: begin
        mem_we     = 1'b1;
        mem_waddr  = ptr[AW-1:0];
        mem_wdata  = mem_rdata;
        ptr_next   = ptr_dec;
        state_next = sckt_pkg::ST_SHRD;
      end

      sckt_pkg::ST_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = pos[AW-1:0];
        mem_wdata  = new_entry;
        count_next = count + CW'(1);
        state_next = sckt_pkg::ST_DONE;
      end

      // extend the run of equal keys downward
      sckt_pkg::ST_DNRD: begin
        if (first != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = first_dec[AW-1:0];
          state_next = sckt_pkg::ST_DNCMP;
        end else begin
          state_next = sckt_pkg::ST_UPRD;
        end
      end

      sckt_pkg::ST_DNCMP: begin
        if (cmp == sckt_pkg::CMP_EQ) begin
          first_next   = first_dec;
          run_len_next = run_len + CW'(1);
          state_next   = sckt_pkg::ST_DNRD;
        end else begin
          state_next = sckt_pkg::ST_UPRD;
        end
      end

      // then upward
      sckt_pkg::ST_UPRD: begin
        if (up_addr < {1'b0, count}) begin
          mem_re     = 1'b1;
          mem_raddr  = up_addr[AW-1:0];
          state_next = sckt_pkg::ST_UPCMP;
        end else begin
          res_start_next  = 6'(first);
          res_mcount_next = 7'(run_len);
          state_next      = sckt_pkg::ST_DONE;
        end
      end

      sckt_pkg::ST_UPCMP: begin
        if (cmp == sckt_pkg::CMP_EQ) begin
          run_len_next = run_len + CW'(1);
          state_next   = sckt_pkg::ST_UPRD;
        end else begin
          res_start_next  = 6'(first);
          res_mcount_next = 7'(run_len);
          state_next      = sckt_pkg::ST_DONE;
        end
      end

      sckt_pkg::ST_RDWAIT: begin
        res_entry_next = mem_rdata;
        state_next     = sckt_pkg::ST_DONE;
      end

      sckt_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = sckt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = sckt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/sorted_cell_key_table.sv */
// ----------------------------------------------------------------------------
// sorted_cell_key_table
// Table of entries kept sorted by (row, col) with insert, lookup and read.
// ----------------------------------------------------------------------------
//   channel | handshake              | payload
//   --------+------------------------+----------------------
//   req     | req_valid / req_stall  | sckt_pkg::req_t
//   rsp     | rsp_valid / rsp_stall  | sckt_pkg::rsp_t
//
// One transaction at a time: accept, do the work, then hand off the result.
// Read: one store read; search: a read and a compare per probe; insert then
// reads and writes each shifted entry and writes the slot; a lookup hit
// reads and compares each run neighbor. Full, bad index, unused: no work.
// Reset clears the count but not the store, which needs no clearing. A result
// held by rsp_stall waits in the output register while the sequencer runs on.
module sorted_cell_key_table #(
  parameter int TABLE_DEPTH = sckt_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sckt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sckt_pkg::rsp_t rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic             res_valid;
  logic             res_ready;
  sckt_pkg::rsp_t   res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  sckt_pkg::entry_t mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  sckt_pkg::entry_t mem_rdata;

  sckt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sckt_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

/* sv/sckt_checker.sv */
// ----------------------------------------------------------------------------
// sckt_checker
// Port-level checks for the sorted cell key table, bound to the top level.
// ----------------------------------------------------------------------------
module sckt_checker #(
  parameter int TABLE_DEPTH = sckt_pkg::TABLE_DEPTH_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input sckt_pkg::rsp_t rsp
);

  // a held result does not change
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // one transaction in flight: busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one still in flight");

  // a full status only shows with the table at capacity
  a_full_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == sckt_pkg::STAT_FULL |->
      rsp.entry_total == 7'(TABLE_DEPTH))
    else $error("full status with table below capacity");

  // bad index gives no entry data
  a_bad_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == sckt_pkg::STAT_BAD_INDEX |->
      !rsp.found && rsp.entry_arg_ref == '0 && rsp.entry_col == '0 &&
      rsp.entry_row == '0)
    else $error("bad-index result carries entry data");

  // a hit has a run of at least one and an ok status
  a_found_run: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |->
      rsp.match_count != '0 && rsp.status == sckt_pkg::STAT_OK)
    else $error("lookup hit with empty run");

endmodule

bind sorted_cell_key_table sckt_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_sckt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

/* verif/sckt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sckt_scoreboard
// Watches both channels of the sorted cell key table, keeps its own sorted
// copy of the entries, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module sckt_scoreboard #(
  parameter int TABLE_DEPTH = sckt_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  sckt_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  sckt_pkg::rsp_t rsp,
  output int             fail_count,
  output int             pending
);

  sckt_pkg::entry_t shadow_entries [TABLE_DEPTH];
  int               shadow_count;
  sckt_pkg::rsp_t   outcome_q [$];
  int               errors = 0;

  function automatic logic [15:0] key_at(int i);
    return {shadow_entries[i].row, shadow_entries[i].col};
  endfunction

  // binary search, midpoint (lo+hi)/2; on a miss pos is the insert slot
  function automatic bit locate_key(input logic [15:0] key, output int pos);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (key < key_at(mid)) begin
        hi = mid;
      end else if (key > key_at(mid)) begin
        lo = mid + 1;
      end else begin
        pos = mid;
        return 1'b1;
      end
    end
    pos = lo;
    return 1'b0;
  endfunction

  function automatic sckt_pkg::rsp_t table_outcome(sckt_pkg::req_t r);
    sckt_pkg::rsp_t res;
    logic [15:0]    key;
    int             pos;
    int             first;
    int             run;
    res = '0;
    key = {r.row, r.col};
    case (r.operation)
      sckt_pkg::OP_INSERT: begin
        if (shadow_count >= TABLE_DEPTH) begin
          res.status = sckt_pkg::STAT_FULL;
        end else begin
          void'(locate_key(key, pos));
          for (int i = shadow_count; i > pos; i--) begin
            shadow_entries[i] = shadow_entries[i - 1];
          end
          shadow_entries[pos] = '{col: r.col, row: r.row, kind: r.kind,
                                  arg_ref: r.arg_ref, arg_count: r.arg_count};
          shadow_count++;
          res.start_index = pos[5:0];
        end
      end
      sckt_pkg::OP_LOOKUP: begin
        if (locate_key(key, pos)) begin
          first = pos;
          run = 1;
          while (first > 0 && key_at(first - 1) == key) begin
            first--;
            run++;
          end
          while (first + run < shadow_count && key_at(first + run) == key) begin
            run++;
          end
          res.found = 1'b1;
          res.start_index = first[5:0];
          res.match_count = run[6:0];
        end else begin
          res.start_index = pos[5:0];
        end
      end
      sckt_pkg::OP_READ: begin
        if (r.index >= shadow_count) begin
          res.status = sckt_pkg::STAT_BAD_INDEX;
        end else begin
          res.entry_col = shadow_entries[r.index].col;
          res.entry_row = shadow_entries[r.index].row;
          res.entry_kind = shadow_entries[r.index].kind;
          res.entry_arg_ref = shadow_entries[r.index].arg_ref;
          res.entry_arg_count = shadow_entries[r.index].arg_count;
        end
      end
      default: begin
      end
    endcase
    res.entry_total = shadow_count[6:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic compare_outcome(sckt_pkg::rsp_t got);
    sckt_pkg::rsp_t want;
    if (outcome_q.size() == 0) begin
      $error("response transaction with nothing outstanding");
      errors++;
    end else begin
      want = outcome_q.pop_front();
      check_field("status", want.status, got.status);
      check_field("found", want.found, got.found);
      check_field("start_index", want.start_index, got.start_index);
      check_field("match_count", want.match_count, got.match_count);
      check_field("entry_col", want.entry_col, got.entry_col);
      check_field("entry_row", want.entry_row, got.entry_row);
      check_field("entry_kind", want.entry_kind, got.entry_kind);
      check_field("entry_arg_ref", want.entry_arg_ref, got.entry_arg_ref);
      check_field("entry_arg_count", want.entry_arg_count, got.entry_arg_count);
      check_field("entry_total", want.entry_total, got.entry_total);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      outcome_q.delete();
    end else begin
      // one transaction in flight at a time, so the response is checked first
      if (rsp_valid && !rsp_stall) begin
        compare_outcome(rsp);
      end
      if (req_valid && !req_stall) begin
        outcome_q.push_back(table_outcome(req));
      end
    end
    fail_count <= errors;
    pending <= outcome_q.size();
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random table operations into the sorted cell key table
// with random idle cycles on both channels and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1900;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  sckt_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_stall;
  sckt_pkg::rsp_t rsp;
  int             fail_count;
  int             pending;
  bit             calm;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  sorted_cell_key_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  sckt_scoreboard i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !calm && ($urandom_range(99) < 15);
    end
  end

  function automatic sckt_pkg::req_t make_req(logic [1:0] op, logic [7:0] row,
                                              logic [7:0] col, logic [1:0] kind,
                                              logic [15:0] aref, logic [7:0] acnt,
                                              logic [5:0] idx);
    return '{operation: op, col: col, row: row, kind: kind, arg_ref: aref,
             arg_count: acnt, index: idx};
  endfunction

  // mostly a small set of coordinates so lookups hit and duplicates pile up
  function automatic logic [7:0] pick_coord();
    if ($urandom_range(99) < 70) begin
      return 8'($urandom_range(3) * 85);
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic issue(sckt_pkg::req_t r);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 15) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int         sel;
    logic [1:0] op;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table
    issue(make_req(sckt_pkg::OP_LOOKUP, 8'd0, 8'd0, 2'd0, 16'h0000, 8'h00, 6'd0));
    issue(make_req(sckt_pkg::OP_READ, 8'd0, 8'd0, 2'd0, 16'h0000, 8'h00, 6'd0));
    issue(make_req(OP_UNUSED, 8'hff, 8'hff, 2'd3, 16'hffff, 8'hff, 6'd63));
    // key and payload extremes, inserted out of order
    issue(make_req(sckt_pkg::OP_INSERT, 8'hff, 8'hff, 2'd3, 16'hffff, 8'hff, 6'd63));
    issue(make_req(sckt_pkg::OP_INSERT, 8'h00, 8'h00, 2'd0, 16'h0000, 8'h00, 6'd0));
    issue(make_req(sckt_pkg::OP_INSERT, 8'h00, 8'hff, 2'd1, 16'h5a5a, 8'h55, 6'd21));
    issue(make_req(sckt_pkg::OP_INSERT, 8'hff, 8'h00, 2'd2, 16'ha5a5, 8'haa, 6'd42));
    // duplicate keys
    issue(make_req(sckt_pkg::OP_INSERT, 8'd7, 8'd9, 2'd0, 16'h1111, 8'h01, 6'd0));
    issue(make_req(sckt_pkg::OP_INSERT, 8'd7, 8'd9, 2'd1, 16'h2222, 8'h02, 6'd0));
    issue(make_req(sckt_pkg::OP_INSERT, 8'd7, 8'd9, 2'd2, 16'h3333, 8'h03, 6'd0));
    issue(make_req(sckt_pkg::OP_LOOKUP, 8'd7, 8'd9, 2'd0, 16'h0000, 8'h00, 6'd0));
    issue(make_req(sckt_pkg::OP_LOOKUP, 8'hff, 8'hff, 2'd0, 16'h0000, 8'h00, 6'd0));
    issue(make_req(sckt_pkg::OP_LOOKUP, 8'h80, 8'h80, 2'd0, 16'h0000, 8'h00, 6'd0));
    issue(make_req(sckt_pkg::OP_LOOKUP, 8'h00, 8'h00, 2'd0, 16'h0000, 8'h00, 6'd0));
    // reads at both ends and past the count
    issue(make_req(sckt_pkg::OP_READ, 8'd0, 8'd0, 2'd0, 16'h0000, 8'h00, 6'd0));
    issue(make_req(sckt_pkg::OP_READ, 8'd0, 8'd0, 2'd0, 16'h0000, 8'h00, 6'd6));
    issue(make_req(sckt_pkg::OP_READ, 8'd0, 8'd0, 2'd0, 16'h0000, 8'h00, 6'd7));
    issue(make_req(sckt_pkg::OP_READ, 8'd0, 8'd0, 2'd0, 16'h0000, 8'h00, 6'd63));
    issue(make_req(OP_UNUSED, 8'd0, 8'd0, 2'd0, 16'h0000, 8'h00, 6'd0));

    // the table fills part way through; later inserts see a full table
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 800 && n < 1100);
      sel = $urandom_range(99);
      if (sel < 12) begin
        op = sckt_pkg::OP_INSERT;
      end else if (sel < 52) begin
        op = sckt_pkg::OP_LOOKUP;
      end else if (sel < 95) begin
        op = sckt_pkg::OP_READ;
      end else begin
        op = OP_UNUSED;
      end
      issue(make_req(op, pick_coord(), pick_coord(), 2'($urandom_range(3)),
                     16'($urandom_range(65535)), 8'($urandom_range(255)),
                     6'($urandom_range(63))));
    end
    calm = 1'b0;
    @(negedge clk);
    req_valid <= 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sckt_pkg.sv
sv/sckt_mem.sv
sv/sckt_ctrl.sv
sv/sorted_cell_key_table.sv
sv/sckt_checker.sv
verif/sckt_checker.sv
verif/tb_top.sv
